/* rtl/bcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 32'd1000;
  localparam logic [CFG_W-1:0] WINDOW_RST    = 32'd300000;
  localparam logic [CFG_W-1:0] LONG_RST      = 32'd800000;
  localparam logic             PRESSED_RST   = 1'b0;
  // the released level is the inverse of the pressed level at reset
  localparam logic             RELEASED_RST  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_PRESSED       = 3'd1,
    PH_RELEASED      = 3'd2,
    PH_COUNTING      = 3'd3,
    PH_HELD          = 3'd4,
    PH_HELD_RELEASED = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    G_NONE   = 2'd0,
    G_SINGLE = 2'd1,
    G_DOUBLE = 2'd2,
    G_LONG   = 2'd3
  } gesture_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_LONG     = 2'd2,
    REG_PRESSED  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] click_window;
    logic [CFG_W-1:0] long_press_time;
    logic             pressed_level;
  } cfg_t;

  localparam logic [1:0] CLICKS_MAX = 2'd3;
  localparam logic [1:0] CLICKS_ONE = 2'd1;
  localparam logic [1:0] CLICKS_TWO = 2'd2;

endpackage

/* rtl/bcc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_in_if / bcc_out_if
// Valid/ready channels for button samples and classified gestures.
// ----------------------------------------------------------------------------
interface bcc_in_if #(
  parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 raw_level;
  logic [TIME_BITS-1:0] timestamp;

  modport source (output valid, output raw_level, output timestamp, input ready);
  modport sink   (input valid, input raw_level, input timestamp, output ready);
endinterface

interface bcc_out_if ();
  logic             valid;
  logic             ready;
  bcc_pkg::gesture_t gesture;

  modport source (output valid, output gesture, input ready);
  modport sink   (input valid, input gesture, output ready);
endinterface

/* rtl/button_click_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounced single, double and long press detector on timestamped samples.
// ----------------------------------------------------------------------------
// Each accepted sample word (raw pin level plus a free-running microsecond
// timestamp) produces exactly one gesture word: none, single, double or long.
// A sample is taken every ready cycle; its result lands in the output register
// the cycle after acceptance. The whole update (debounce compare, press timer
// compares and the phase machine) sits between the sample port and that
// register, so throughput is one word per clock while the output is drained.
// Configuration writes take effect immediately and are meant for idle periods.
module button_click_classifier #(
  parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bcc_in_if.sink                          in_if,
  bcc_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcc_pkg::CFG_W-1:0]       cfg_data
);

  bcc_pkg::cfg_t     cfg_r;
  logic              out_valid_r;
  bcc_pkg::gesture_t gesture_r;
  bcc_pkg::gesture_t gesture_nxt;
  logic              accept;

  // take a new word whenever the output register is empty or being drained
  assign in_if.ready    = !out_valid_r || out_if.ready;
  assign accept         = in_if.valid && in_if.ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.gesture = gesture_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time   <= bcc_pkg::DEBOUNCE_RST;
      cfg_r.click_window    <= bcc_pkg::WINDOW_RST;
      cfg_r.long_press_time <= bcc_pkg::LONG_RST;
      cfg_r.pressed_level   <= bcc_pkg::PRESSED_RST;
    end else if (cfg_we) begin
      unique case (bcc_pkg::cfg_reg_t'(cfg_index))
        bcc_pkg::REG_DEBOUNCE: cfg_r.debounce_time   <= cfg_data;
        bcc_pkg::REG_WINDOW:   cfg_r.click_window    <= cfg_data;
        bcc_pkg::REG_LONG:     cfg_r.long_press_time <= cfg_data;
        bcc_pkg::REG_PRESSED:  cfg_r.pressed_level   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bcc_classifier #(
    .TIME_BITS (TIME_BITS)
  ) u_classifier (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .raw_level (in_if.raw_level),
    .timestamp (in_if.timestamp),
    .gesture   (gesture_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      gesture_r <= gesture_nxt;
    end
  end

endmodule

/* rtl/bcc_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_classifier
// Debounce filter and gesture state machine, updated once per accepted word.
// ----------------------------------------------------------------------------
module bcc_classifier #(
  parameter int TIME_BITS = bcc_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bcc_pkg::cfg_t        cfg,
  input  logic                 accept,
  input  logic                 raw_level,
  input  logic [TIME_BITS-1:0] timestamp,
  output bcc_pkg::gesture_t    gesture
);

  logic                 stable_r,    stable_nxt;
  logic                 prev_raw_r;
  logic [TIME_BITS-1:0] last_chg_r,  last_chg_nxt;
  bcc_pkg::phase_t      phase_r,     phase_nxt;
  logic [TIME_BITS-1:0] mark_r,      mark_nxt;
  logic [1:0]           clicks_r,    clicks_nxt;

  logic [TIME_BITS-1:0] debounce_t, window_t, long_t;
  logic [TIME_BITS-1:0] since_chg, held_for;
  logic                 down;
  logic                 window_done;

  assign debounce_t = TIME_BITS'(cfg.debounce_time);
  assign window_t   = TIME_BITS'(cfg.click_window);
  assign long_t     = TIME_BITS'(cfg.long_press_time);

  // debounce: restart the quiet timer on any raw change
  always_comb begin
    last_chg_nxt = (raw_level != prev_raw_r) ? timestamp : last_chg_r;
    since_chg    = timestamp - last_chg_nxt;
    stable_nxt   = (since_chg >= debounce_t) ? raw_level : stable_r;
  end

  assign down        = (stable_nxt == cfg.pressed_level);
  assign held_for    = timestamp - mark_r;
  assign window_done = (held_for >= window_t) || (clicks_r == bcc_pkg::CLICKS_TWO);

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    mark_nxt   = mark_r;
    clicks_nxt = clicks_r;
    unique case (phase_r)
      bcc_pkg::PH_IDLE: begin
        if (down) begin
          phase_nxt  = bcc_pkg::PH_PRESSED;
          mark_nxt   = timestamp;
          clicks_nxt = '0;
        end
      end
      bcc_pkg::PH_PRESSED: begin
        if (!down) begin
          phase_nxt = bcc_pkg::PH_RELEASED;
          mark_nxt  = timestamp;
        end else if (held_for > long_t) begin
          phase_nxt = bcc_pkg::PH_HELD;
        end
      end
      bcc_pkg::PH_RELEASED: begin
        if (clicks_r != bcc_pkg::CLICKS_MAX) begin
          clicks_nxt = clicks_r + 2'd1;
        end
        phase_nxt = bcc_pkg::PH_COUNTING;
      end
      bcc_pkg::PH_COUNTING: begin
        if (down) begin
          phase_nxt = bcc_pkg::PH_PRESSED;
          mark_nxt  = timestamp;
        end else if (window_done) begin
          phase_nxt  = bcc_pkg::PH_IDLE;
          mark_nxt   = '0;
          clicks_nxt = '0;
        end
      end
      bcc_pkg::PH_HELD: begin
        if (!down) begin
          phase_nxt = bcc_pkg::PH_HELD_RELEASED;
          mark_nxt  = timestamp;
        end
      end
      default: begin
        // held-released and unused codes: drop back to idle
        phase_nxt  = bcc_pkg::PH_IDLE;
        mark_nxt   = '0;
        clicks_nxt = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    gesture = bcc_pkg::G_NONE;
    unique case (phase_r)
      bcc_pkg::PH_PRESSED: begin
        if (down && (held_for > long_t)) gesture = bcc_pkg::G_LONG;
      end
      bcc_pkg::PH_COUNTING: begin
        if (!down && window_done) begin
          if (clicks_r == bcc_pkg::CLICKS_ONE) gesture = bcc_pkg::G_SINGLE;
          else if (clicks_r == bcc_pkg::CLICKS_TWO) gesture = bcc_pkg::G_DOUBLE;
        end
      end
      default: gesture = bcc_pkg::G_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r   <= bcc_pkg::RELEASED_RST;
      prev_raw_r <= bcc_pkg::RELEASED_RST;
      last_chg_r <= '0;
      phase_r    <= bcc_pkg::PH_IDLE;
      mark_r     <= '0;
      clicks_r   <= '0;
    end else if (accept) begin
      stable_r   <= stable_nxt;
      prev_raw_r <= raw_level;
      last_chg_r <= last_chg_nxt;
      phase_r    <= phase_nxt;
      mark_r     <= mark_nxt;
      clicks_r   <= clicks_nxt;
    end
  end

endmodule

/* rtl/bcc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the classifier handshake and output register.
// ----------------------------------------------------------------------------
module bcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_gesture
);

  // a waiting word must not block the input once it is being drained
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output register free");

  // every accepted word shows up in the output register next cycle
  a_accept_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word produced no result");

  // no result appears without an accepted word behind it
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && in_ready) && (!out_valid || out_ready)) |=> !out_valid)
    else $error("result without accepted word");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_gesture)))
    else $error("stalled result changed");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_gesture (out_if.gesture)
);
